// ===== rtl/core/ftqg_pkg.sv =====
// shared types, constants and tier table for the frame time quality governor
package ftqg_pkg;

   localparam int FT_W       = 20;
   localparam int SCREEN_W   = 7;
   localparam int SHADOW_W   = 2;
   localparam int DIR_W      = 2;
   localparam int TIER_W     = 3;
   localparam int INTERVAL_W = 20;
   localparam int RUNS_W     = 4;
   localparam int FPS_W      = 7;
   localparam int ACCUM_W    = INTERVAL_W + 1;
   localparam int PROD_W     = FT_W + FPS_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [FT_W-1:0]       FRAME_MAX      = FT_W'(1000000);
   localparam logic [TIER_W-1:0]     TIER_MAX       = TIER_W'(4);
   localparam logic [TIER_W-1:0]     TIER_RESET     = TIER_W'(2);
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(500000);
   localparam logic [RUNS_W-1:0]     REDUCE_RESET   = RUNS_W'(3);
   localparam logic [RUNS_W-1:0]     RECOVER_RESET  = RUNS_W'(5);

   // avg*fps*100 against 115000000 and 80000000, with the factor 100 taken out
   localparam logic [PROD_W-1:0] SLOW_LIMIT = PROD_W'(1150000);
   localparam logic [PROD_W-1:0] FAST_LIMIT = PROD_W'(800000);

   localparam logic [CSR_IDX_W-1:0] CSR_TIER     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_REDUCE   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVER  = CSR_IDX_W'(3);

   typedef enum logic [DIR_W-1:0] {
      DIR_STABLE  = 2'd0,
      DIR_REDUCE  = 2'd1,
      DIR_RECOVER = 2'd2
   } dir_type;

   typedef struct packed {
      logic [FPS_W-1:0]    fps;
      logic [SHADOW_W-1:0] shadow_min;
      logic [SHADOW_W-1:0] shadow_max;
      logic [SCREEN_W-1:0] screen_min;
      logic [SCREEN_W-1:0] screen_max;
      logic [SHADOW_W-1:0] shadow_start;
      logic [SCREEN_W-1:0] screen_start;
   } tier_row_type;

   function automatic tier_row_type tier_row(input logic [TIER_W-1:0] tier);
      tier_row_type row;
      case (tier)
         3'd0:    row = '{7'd30, 2'd0, 2'd0, 7'd40, 7'd60,  2'd0, 7'd50};
         3'd1:    row = '{7'd30, 2'd0, 2'd1, 7'd50, 7'd75,  2'd0, 7'd60};
         3'd2:    row = '{7'd60, 2'd0, 2'd2, 7'd60, 7'd90,  2'd1, 7'd78};
         3'd3:    row = '{7'd60, 2'd1, 2'd3, 7'd75, 7'd100, 2'd2, 7'd90};
         default: row = '{7'd60, 2'd2, 2'd3, 7'd90, 7'd100, 2'd3, 7'd100};
      endcase
      return row;
   endfunction

endpackage

// ===== rtl/core/ftqg_ring.sv =====
// sample window memory, one write port and one registered read port
module ftqg_ring #(
   parameter int DEPTH = 120,
   parameter int ADDR_W = 7
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [ftqg_pkg::FT_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [ftqg_pkg::FT_W-1:0] rd_data
);
   import ftqg_pkg::*;

   logic [FT_W-1:0] mem [DEPTH];
   logic [FT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ftqg_div.sv =====
// restoring divider, one quotient bit per cycle
module ftqg_div #(
   parameter int DIVIDEND_W = 27,
   parameter int DIVISOR_W = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   import ftqg_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      fits      = rem_shift >= {1'b0, dvs_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/frame_time_quality_governor.sv =====
// frame time quality governor: sliding window average and quality stepping
// flow: accept, window update, then the divider and evaluation states when an
//   evaluation runs, and the finish state that loads the result register
// the next beat is taken only after the previous result is registered; a stalled result register holds it back
// reset: synchronous, clears window, runs and direction, loads tier 2 start levels
//   and the default registers; the window memory needs no clearing pass
module frame_time_quality_governor #(
   parameter int WINDOW_DEPTH = 120,
   parameter int MIN_SAMPLES = 10,
   parameter int SCREEN_STEP = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ftqg_pkg::FT_W-1:0]         req_frame_time_us,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_evaluated,
   output logic [ftqg_pkg::FT_W-1:0]         rsp_avg_frame_us,
   output logic [ftqg_pkg::DIR_W-1:0]        rsp_direction,
   output logic [ftqg_pkg::SHADOW_W-1:0]     rsp_shadow_level,
   output logic [ftqg_pkg::SCREEN_W-1:0]     rsp_screen_percent,
   input  logic                              csr_write,
   input  logic [ftqg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ftqg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ftqg_pkg::*;

   localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = FT_W + CNT_W;
   localparam int SCR_X = SCREEN_W + 1;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_DEPTH);
   localparam logic [CNT_W-1:0] MIN_CNT  = CNT_W'(MIN_SAMPLES);
   localparam logic [SCR_X-1:0] STEP_X   = SCR_X'(SCREEN_STEP);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV,
      ST_EVAL,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [TIER_W-1:0]     tier_ff, tier_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [RUNS_W-1:0]     reduce_ff, reduce_in;
   logic [RUNS_W-1:0]     recover_ff, recover_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [ACCUM_W-1:0]    accum_ff, accum_in;
   logic [RUNS_W-1:0]     slow_ff, slow_in;
   logic [RUNS_W-1:0]     fast_ff, fast_in;
   dir_type               dir_ff, dir_in;
   logic [SHADOW_W-1:0]   shadow_ff, shadow_in;
   logic [SCREEN_W-1:0]   screen_ff, screen_in;
   logic [FT_W-1:0]       ft_ff, ft_in;
   logic                  eval_ff, eval_in;
   logic [FT_W-1:0]       avg_ff, avg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_eval_ff, rsp_eval_in;
   logic [FT_W-1:0]       rsp_avg_ff, rsp_avg_in;
   logic [DIR_W-1:0]      rsp_dir_ff, rsp_dir_in;
   logic [SHADOW_W-1:0]   rsp_shadow_ff, rsp_shadow_in;
   logic [SCREEN_W-1:0]   rsp_screen_ff, rsp_screen_in;

   logic                  accept;
   logic                  ring_wr_en;
   logic [FT_W-1:0]       ring_rd_data;
   logic                  div_start;
   logic                  div_done;
   logic [SUM_W-1:0]      div_quotient;
   logic                  full;
   logic [ACCUM_W-1:0]    accum_sum;
   logic [PROD_W-1:0]     scaled;
   logic [RUNS_W-1:0]     slow_next, fast_next;
   logic [RUNS_W-1:0]     need_slow, need_fast;
   logic [SCR_X-1:0]      screen_x;
   logic [TIER_W-1:0]     wr_tier;
   tier_row_type          row;
   tier_row_type          wr_row;

   assign accept    = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);

   ftqg_ring #(
      .DEPTH  (WINDOW_DEPTH),
      .ADDR_W (POS_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (pos_ff),
      .wr_data (ft_ff),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (ring_rd_data)
   );

   ftqg_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (count_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in      = state_ff;
      tier_in       = tier_ff;
      interval_in   = interval_ff;
      reduce_in     = reduce_ff;
      recover_in    = recover_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      accum_in      = accum_ff;
      slow_in       = slow_ff;
      fast_in       = fast_ff;
      dir_in        = dir_ff;
      shadow_in     = shadow_ff;
      screen_in     = screen_ff;
      ft_in         = ft_ff;
      eval_in       = eval_ff;
      avg_in        = avg_ff;
      rsp_eval_in   = rsp_eval_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_shadow_in = rsp_shadow_ff;
      rsp_screen_in = rsp_screen_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ring_wr_en    = 1'b0;
      div_start     = 1'b0;

      row       = tier_row(tier_ff);
      full      = (count_ff == FULL_CNT);
      accum_sum = accum_ff + ACCUM_W'(ft_ff);
      scaled    = PROD_W'(avg_ff) * PROD_W'(row.fps);
      slow_next = slow_ff + 1'b1;
      fast_next = fast_ff + 1'b1;
      need_slow = (reduce_ff == '0) ? RUNS_W'(1) : reduce_ff;
      need_fast = (recover_ff == '0) ? RUNS_W'(1) : recover_ff;
      screen_x  = SCR_X'(screen_ff);
      wr_tier   = (csr_wdata[TIER_W-1:0] > TIER_MAX) ? TIER_MAX : csr_wdata[TIER_W-1:0];
      wr_row    = tier_row(wr_tier);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ft_in    = (req_frame_time_us > FRAME_MAX) ? FRAME_MAX : req_frame_time_us;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // ring read of the oldest entry landed at the accept edge
            sum_in     = sum_ff - (full ? SUM_W'(ring_rd_data) : '0) + SUM_W'(ft_ff);
            count_in   = full ? count_ff : count_ff + 1'b1;
            pos_in     = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
            ring_wr_en = 1'b1;
            eval_in    = 1'b0;
            avg_in     = '0;
            state_in   = ST_FINISH;
            if (accum_sum >= ACCUM_W'(interval_ff)) begin
               accum_in = '0;
               if (count_in >= MIN_CNT) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end else begin
               accum_in = accum_sum;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               avg_in   = div_quotient[FT_W-1:0];
               eval_in  = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (scaled > SLOW_LIMIT) begin
               slow_in = slow_next;
               fast_in = '0;
               if (slow_next >= need_slow) begin
                  slow_in = '0;
                  dir_in  = DIR_REDUCE;
                  if (shadow_ff > row.shadow_min) begin
                     shadow_in = shadow_ff - 1'b1;
                  end else if (screen_ff > row.screen_min) begin
                     screen_in = (screen_x >= SCR_X'(row.screen_min) + STEP_X) ?
                                 SCREEN_W'(screen_x - STEP_X) : row.screen_min;
                  end
               end
            end else if (scaled < FAST_LIMIT) begin
               fast_in = fast_next;
               slow_in = '0;
               if (fast_next >= need_fast) begin
                  fast_in = '0;
                  dir_in  = DIR_RECOVER;
                  if (screen_ff < row.screen_max) begin
                     screen_in = (screen_x + STEP_X <= SCR_X'(row.screen_max)) ?
                                 SCREEN_W'(screen_x + STEP_X) : row.screen_max;
                  end else if (shadow_ff < row.shadow_max) begin
                     shadow_in = shadow_ff + 1'b1;
                  end
               end
            end else begin
               slow_in = '0;
               fast_in = '0;
               dir_in  = DIR_STABLE;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // output register free or emptied this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_eval_in   = eval_ff;
               rsp_avg_in    = avg_ff;
               rsp_dir_in    = dir_ff;
               rsp_shadow_in = shadow_ff;
               rsp_screen_in = screen_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write) begin
         unique case (csr_index)
            CSR_TIER: begin
               tier_in   = wr_tier;
               shadow_in = wr_row.shadow_start;
               screen_in = wr_row.screen_start;
            end
            CSR_INTERVAL: interval_in = csr_wdata[INTERVAL_W-1:0];
            CSR_REDUCE:   reduce_in   = csr_wdata[RUNS_W-1:0];
            CSR_RECOVER:  recover_in  = csr_wdata[RUNS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tier_ff      <= TIER_RESET;
         interval_ff  <= INTERVAL_RESET;
         reduce_ff    <= REDUCE_RESET;
         recover_ff   <= RECOVER_RESET;
         pos_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         accum_ff     <= '0;
         slow_ff      <= '0;
         fast_ff      <= '0;
         dir_ff       <= DIR_STABLE;
         shadow_ff    <= tier_row(TIER_RESET).shadow_start;
         screen_ff    <= tier_row(TIER_RESET).screen_start;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tier_ff      <= tier_in;
         interval_ff  <= interval_in;
         reduce_ff    <= reduce_in;
         recover_ff   <= recover_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         accum_ff     <= accum_in;
         slow_ff      <= slow_in;
         fast_ff      <= fast_in;
         dir_ff       <= dir_in;
         shadow_ff    <= shadow_in;
         screen_ff    <= screen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ft_ff         <= ft_in;
      eval_ff       <= eval_in;
      avg_ff        <= avg_in;
      rsp_eval_ff   <= rsp_eval_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_shadow_ff <= rsp_shadow_in;
      rsp_screen_ff <= rsp_screen_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_evaluated      = rsp_eval_ff;
   assign rsp_avg_frame_us   = rsp_avg_ff;
   assign rsp_direction      = rsp_dir_ff;
   assign rsp_shadow_level   = rsp_shadow_ff;
   assign rsp_screen_percent = rsp_screen_ff;

endmodule

// ===== rtl/core/ftqg_checker.sv =====
// port-level checks for the frame time quality governor, bound to the top level
module ftqg_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_evaluated,
   input logic [ftqg_pkg::FT_W-1:0]         rsp_avg_frame_us,
   input logic [ftqg_pkg::DIR_W-1:0]        rsp_direction,
   input logic [ftqg_pkg::SCREEN_W-1:0]     rsp_screen_percent
);
   import ftqg_pkg::*;

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // the block is busy right after taking a beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while previous beat in progress");

   a_avg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evaluated |-> rsp_avg_frame_us == '0)
      else $error("average reported without evaluation");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_direction != DIR_W'(3))
      else $error("bad direction code");

   a_screen_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_screen_percent >= SCREEN_W'(40) && rsp_screen_percent <= SCREEN_W'(100))
      else $error("screen percent outside every tier bound");

endmodule

bind frame_time_quality_governor ftqg_checker u_ftqg_checker (.*);

// ===== test/tb_frame_time_quality_governor.sv =====
// testbench for the frame time quality governor: directed, backpressure and random phases
`timescale 1ns / 1ps

module tb_frame_time_quality_governor;
   import ftqg_pkg::*;

   localparam int WINDOW_DEPTH      = 120;
   localparam int MIN_SAMPLES       = 10;
   localparam int SCREEN_STEP       = 5;
   localparam int ACCEPT_WAIT_LIMIT = 5000;
   localparam int HOLD_CYCLES       = 300;
   localparam int RANDOM_PHASES     = 12;
   localparam int PHASE_ITEMS       = 150;
   localparam int DRAIN_CYCLES      = 40;
   localparam int PRINT_LIMIT       = 100;

   typedef struct {
      logic                evaluated;
      logic [FT_W-1:0]     avg_us;
      dir_type             direction;
      logic [SHADOW_W-1:0] shadow;
      logic [SCREEN_W-1:0] screen;
   } governor_result_type;

   typedef enum int {LOAD_SLOW, LOAD_FAST, LOAD_STEADY, LOAD_NOISE} load_kind_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [FT_W-1:0]       req_frame_time_us;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_evaluated;
   logic [FT_W-1:0]       rsp_avg_frame_us;
   logic [DIR_W-1:0]      rsp_direction;
   logic [SHADOW_W-1:0]   rsp_shadow_level;
   logic [SCREEN_W-1:0]   rsp_screen_percent;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   frame_time_quality_governor dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_frame_time_us  (req_frame_time_us),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_evaluated      (rsp_evaluated),
      .rsp_avg_frame_us   (rsp_avg_frame_us),
      .rsp_direction      (rsp_direction),
      .rsp_shadow_level   (rsp_shadow_level),
      .rsp_screen_percent (rsp_screen_percent),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   // governor shadow state
   logic [FT_W-1:0]       win_ring [WINDOW_DEPTH];
   int                    win_pos;
   int                    win_count;
   logic [26:0]           win_sum;
   logic [ACCUM_W-1:0]    interval_acc;
   logic [RUNS_W-1:0]     slow_run;
   logic [RUNS_W-1:0]     fast_run;
   dir_type               tune_dir;
   logic [SHADOW_W-1:0]   shadow_now;
   logic [SCREEN_W-1:0]   screen_now;
   logic [TIER_W-1:0]     cur_tier;
   logic [INTERVAL_W-1:0] cfg_interval;
   logic [RUNS_W-1:0]     cfg_reduce;
   logic [RUNS_W-1:0]     cfg_recover;

   governor_result_type pending_results [$];
   governor_result_type oldest;
   int mismatches = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_ticket = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   function automatic tier_row_type tier_entry(input logic [TIER_W-1:0] t);
      tier_row_type row;
      case (t)
         3'd0:    row = '{7'd30, 2'd0, 2'd0, 7'd40, 7'd60,  2'd0, 7'd50};
         3'd1:    row = '{7'd30, 2'd0, 2'd1, 7'd50, 7'd75,  2'd0, 7'd60};
         3'd2:    row = '{7'd60, 2'd0, 2'd2, 7'd60, 7'd90,  2'd1, 7'd78};
         3'd3:    row = '{7'd60, 2'd1, 2'd3, 7'd75, 7'd100, 2'd2, 7'd90};
         default: row = '{7'd60, 2'd2, 2'd3, 7'd90, 7'd100, 2'd3, 7'd100};
      endcase
      return row;
   endfunction

   task automatic select_tier(input logic [TIER_W-1:0] t);
      tier_row_type row;
      cur_tier = (t > TIER_MAX) ? TIER_MAX : t;
      row = tier_entry(cur_tier);
      shadow_now = row.shadow_start;
      screen_now = row.screen_start;
   endtask

   task automatic governor_reset();
      for (int i = 0; i < WINDOW_DEPTH; i++) win_ring[i] = '0;
      win_pos = 0;
      win_count = 0;
      win_sum = '0;
      interval_acc = '0;
      slow_run = '0;
      fast_run = '0;
      tune_dir = DIR_STABLE;
      cfg_interval = INTERVAL_RESET;
      cfg_reduce = REDUCE_RESET;
      cfg_recover = RECOVER_RESET;
      select_tier(TIER_RESET);
   endtask

   task automatic governor_config(input logic [CSR_IDX_W-1:0] idx,
                                  input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_TIER:     select_tier(data[TIER_W-1:0]);
         CSR_INTERVAL: cfg_interval = data[INTERVAL_W-1:0];
         CSR_REDUCE:   cfg_reduce = data[RUNS_W-1:0];
         CSR_RECOVER:  cfg_recover = data[RUNS_W-1:0];
         default:      ;
      endcase
   endtask

   task automatic governor_step(input logic [FT_W-1:0] raw, output governor_result_type res);
      logic [FT_W-1:0]   ft;
      tier_row_type      row;
      longint unsigned   scaled;
      logic [RUNS_W-1:0] need_slow;
      logic [RUNS_W-1:0] need_fast;
      ft = (raw > FRAME_MAX) ? FRAME_MAX : raw;
      row = tier_entry(cur_tier);
      res.evaluated = 1'b0;
      res.avg_us = '0;
      if (win_count >= WINDOW_DEPTH) win_sum = win_sum - win_ring[win_pos];
      else win_count++;
      win_ring[win_pos] = ft;
      win_sum = win_sum + ft;
      win_pos = (win_pos + 1 >= WINDOW_DEPTH) ? 0 : win_pos + 1;
      interval_acc = interval_acc + ft;
      if (interval_acc >= cfg_interval) begin
         interval_acc = '0;
         if (win_count >= MIN_SAMPLES) begin
            need_slow = (cfg_reduce == 0) ? RUNS_W'(1) : cfg_reduce;
            need_fast = (cfg_recover == 0) ? RUNS_W'(1) : cfg_recover;
            res.evaluated = 1'b1;
            res.avg_us = FT_W'(win_sum / 27'(win_count));
            scaled = 64'(res.avg_us) * 64'(row.fps) * 64'd100;
            if (scaled > 64'd115000000) begin
               slow_run = slow_run + 1'b1;
               fast_run = '0;
               if (slow_run >= need_slow) begin
                  slow_run = '0;
                  tune_dir = DIR_REDUCE;
                  // shadow goes first, then resolution
                  if (shadow_now > row.shadow_min) shadow_now = shadow_now - 1'b1;
                  else if (screen_now > row.screen_min)
                     screen_now = (screen_now >= row.screen_min + SCREEN_STEP) ?
                                  SCREEN_W'(screen_now - SCREEN_STEP) : row.screen_min;
               end
            end else if (scaled < 64'd80000000) begin
               fast_run = fast_run + 1'b1;
               slow_run = '0;
               if (fast_run >= need_fast) begin
                  fast_run = '0;
                  tune_dir = DIR_RECOVER;
                  // resolution comes back first, then shadow
                  if (screen_now < row.screen_max)
                     screen_now = (screen_now + SCREEN_STEP <= row.screen_max) ?
                                  SCREEN_W'(screen_now + SCREEN_STEP) : row.screen_max;
                  else if (shadow_now < row.shadow_max) shadow_now = shadow_now + 1'b1;
               end
            end else begin
               slow_run = '0;
               fast_run = '0;
               tune_dir = DIR_STABLE;
            end
         end
      end
      res.direction = tune_dir;
      res.shadow = shadow_now;
      res.screen = screen_now;
   endtask

   function automatic logic [FT_W-1:0] pick_frame(input load_kind_type kind);
      tier_row_type row;
      int unsigned target;
      int unsigned pct;
      int unsigned v;
      row = tier_entry(cur_tier);
      target = 1000000 / row.fps;
      case (kind)
         LOAD_SLOW:   pct = $urandom_range(220, 125);
         LOAD_FAST:   pct = $urandom_range(75, 30);
         LOAD_STEADY: pct = $urandom_range(112, 84);
         default:     pct = 0;
      endcase
      v = target * pct / 100;
      if (kind == LOAD_NOISE || $urandom_range(99) < 3) v = $urandom_range(20'hFFFFF, 0);
      return FT_W'(v);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // lower valid and wait until every outstanding frame has its result
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      governor_config(idx, data);
   endtask

   task automatic send_frame(input logic [FT_W-1:0] ft);
      governor_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frame_time_us <= ft;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      governor_step(ft, res);
      pending_results.push_back(res);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 65; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 65; end
         default: begin send_idle_pct = 10; rsp_stall_pct = 10; end
      endcase
   endtask

   task automatic test_directed();
      logic [FT_W-1:0] first_frames [9];
      first_frames = '{20'd0, 20'hAAAAA, 20'h55555, 20'd1, 20'hFFFFF,
                       20'd1000000, 20'd1000001, 20'd0, 20'd16667};
      set_idling(0);
      // index past the register list, then an out of range tier
      write_reg(CSR_IDX_W'(5), 20'hFFFFF);
      write_reg(CSR_TIER, 20'd7);
      write_reg(CSR_INTERVAL, 20'd0);
      write_reg(CSR_REDUCE, 20'd0);
      write_reg(CSR_RECOVER, 20'd0);
      // too few samples: the interval is met but nothing is evaluated
      foreach (first_frames[i]) send_frame(first_frames[i]);
      // slow evaluations walk shadow then screen down to the tier floor
      repeat (6) send_frame(20'd1000000);
      write_reg(CSR_TIER, 20'd2);
      write_reg(CSR_REDUCE, 20'd2);
      repeat (6) send_frame(20'hFFFFF);
      wait_idle();
   endtask

   task automatic test_backpressure();
      set_idling(0);
      write_reg(CSR_TIER, 20'd3);
      write_reg(CSR_INTERVAL, 20'd1);
      write_reg(CSR_RECOVER, 20'd1);
      hold_ticket++;
      repeat (20) send_frame(pick_frame(LOAD_FAST));
      wait_idle();
   endtask

   task automatic test_random_phase(input int phase);
      int left;
      int run_len;
      int pick;
      load_kind_type kind;
      logic [CSR_DATA_W-1:0] data;
      tier_row_type row;
      set_idling(phase % 4);
      data = CSR_DATA_W'($urandom);
      write_reg(CSR_TIER, {data[CSR_DATA_W-1:TIER_W], TIER_W'(phase % 8)});
      row = tier_entry(cur_tier);
      case (phase)
         1: data = 20'd0;
         2: data = 20'd1;
         3: data = 20'hFFFFF;
         default: data = 20'((1000000 / row.fps) * $urandom_range(3, 1));
      endcase
      write_reg(CSR_INTERVAL, data);
      data = CSR_DATA_W'($urandom);
      case (phase)
         0: data[RUNS_W-1:0] = 4'd1;
         1: data[RUNS_W-1:0] = 4'd15;
         2: data[RUNS_W-1:0] = 4'd0;
         default: data[RUNS_W-1:0] = RUNS_W'($urandom_range(15, 1));
      endcase
      write_reg(CSR_REDUCE, data);
      data = CSR_DATA_W'($urandom);
      case (phase)
         0: data[RUNS_W-1:0] = 4'd15;
         1: data[RUNS_W-1:0] = 4'd1;
         2: data[RUNS_W-1:0] = 4'd0;
         default: data[RUNS_W-1:0] = RUNS_W'($urandom_range(15, 1));
      endcase
      write_reg(CSR_RECOVER, data);
      if (phase % 3 == 0) write_reg(CSR_IDX_W'($urandom_range(7, 4)), CSR_DATA_W'($urandom));
      left = PHASE_ITEMS;
      while (left > 0) begin
         pick = $urandom_range(99);
         kind = (pick < 35) ? LOAD_SLOW : (pick < 70) ? LOAD_FAST :
                (pick < 90) ? LOAD_STEADY : LOAD_NOISE;
         run_len = $urandom_range(50, 10);
         for (int i = 0; i < run_len && left > 0; i++) begin
            send_frame(pick_frame(kind));
            left--;
         end
      end
      wait_idle();
   endtask

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with no frame outstanding");
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_evaluated !== oldest.evaluated)
               report_mismatch($sformatf("evaluated got %0d want %0d",
                                         rsp_evaluated, oldest.evaluated));
            if (rsp_avg_frame_us !== oldest.avg_us)
               report_mismatch($sformatf("avg_frame_us got %0d want %0d",
                                         rsp_avg_frame_us, oldest.avg_us));
            if (rsp_direction !== oldest.direction)
               report_mismatch($sformatf("direction got %0d want %0d",
                                         rsp_direction, oldest.direction));
            if (rsp_shadow_level !== oldest.shadow)
               report_mismatch($sformatf("shadow_level got %0d want %0d",
                                         rsp_shadow_level, oldest.shadow));
            if (rsp_screen_percent !== oldest.screen)
               report_mismatch($sformatf("screen_percent got %0d want %0d",
                                         rsp_screen_percent, oldest.screen));
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= ACCEPT_WAIT_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_frame_time_us <= '0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      governor_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      for (int p = 0; p < RANDOM_PHASES; p++) test_random_phase(p);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
